>>> sv/iphc_pkg.sv
package iphc_pkg;

  // verdict codes, first matching check wins
  typedef enum logic [2:0] {
    VERDICT_ACCEPT      = 3'd0,
    VERDICT_TTL_ZERO    = 3'd1,
    VERDICT_BAD_VERSION = 3'd2,
    VERDICT_SHORT_HDR   = 3'd3,
    VERDICT_WRONG_DEST  = 3'd4,
    VERDICT_BAD_CSUM    = 3'd5,
    VERDICT_TRUNCATED   = 3'd6
  } verdict_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [15:0] packet_length;
  } out_item_t;

  localparam logic [3:0]  IP_VERSION       = 4'd4;
  localparam logic [3:0]  MIN_HEADER_WORDS = 4'd5;
  localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
  localparam logic [15:0] TTL_INDEX        = 16'd8;
  localparam logic [15:0] DEST_FIRST_INDEX = 16'd16;
  localparam logic [15:0] DEST_LAST_INDEX  = 16'd19;
  localparam logic [15:0] COUNT_MAX        = 16'hffff;
  localparam logic [15:0] CSUM_GOOD        = 16'hffff;
  localparam logic [31:0] BROADCAST_ADDR   = 32'hffff_ffff;

endpackage

>>> sv/iphc_accum.sv
module iphc_accum (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  iphc_pkg::in_item_t item,
  input  logic [31:0]        local_address,
  output iphc_pkg::out_item_t result
);
  import iphc_pkg::*;

  logic [15:0] byte_count_r,       byte_count_nxt;
  logic [3:0]  header_words_r,     header_words_nxt;
  logic [3:0]  version_seen_r,     version_seen_nxt;
  logic [7:0]  ttl_seen_r,         ttl_seen_nxt;
  logic [31:0] destination_seen_r, destination_seen_nxt;
  logic [7:0]  pending_high_byte_r, pending_high_byte_nxt;
  logic [20:0] ones_sum_r,         ones_sum_nxt;

  logic [15:0] idx;
  logic [15:0] hdr_bytes;
  logic [15:0] need;
  logic        in_header;
  logic [16:0] fold1;
  logic [15:0] fold2;
  verdict_t    verdict;

  // field capture and running sum for the current byte
  always_comb begin
    idx                  = byte_count_r;
    header_words_nxt     = header_words_r;
    version_seen_nxt     = version_seen_r;
    ttl_seen_nxt         = ttl_seen_r;
    destination_seen_nxt = destination_seen_r;
    pending_high_byte_nxt = pending_high_byte_r;
    ones_sum_nxt         = ones_sum_r;
    if (idx == 16'd0) begin
      version_seen_nxt = item.packet_byte[7:4];
      header_words_nxt = item.packet_byte[3:0];
    end
    if (idx == TTL_INDEX) begin
      ttl_seen_nxt = item.packet_byte;
    end
    if (idx >= DEST_FIRST_INDEX && idx <= DEST_LAST_INDEX) begin
      destination_seen_nxt = {destination_seen_r[23:0], item.packet_byte};
    end
    hdr_bytes = {10'd0, header_words_nxt, 2'b00};
    in_header = idx < hdr_bytes;
    if (in_header) begin
      if (!idx[0]) begin
        pending_high_byte_nxt = item.packet_byte;
      end else begin
        ones_sum_nxt = ones_sum_r + {5'd0, pending_high_byte_r, item.packet_byte};
      end
    end
    byte_count_nxt = (idx != COUNT_MAX) ? idx + 16'd1 : idx;
  end

  // verdict from the updated state, checks in priority order
  always_comb begin
    need  = (header_words_nxt >= MIN_HEADER_WORDS) ? hdr_bytes : MIN_HEADER_BYTES;
    fold1 = {1'b0, ones_sum_nxt[15:0]} + {12'd0, ones_sum_nxt[20:16]};
    fold2 = fold1[15:0] + {15'd0, fold1[16]};
    if (byte_count_nxt < need) begin
      verdict = VERDICT_TRUNCATED;
    end else if (ttl_seen_nxt == 8'd0) begin
      verdict = VERDICT_TTL_ZERO;
    end else if (version_seen_nxt != IP_VERSION) begin
      verdict = VERDICT_BAD_VERSION;
    end else if (header_words_nxt < MIN_HEADER_WORDS) begin
      verdict = VERDICT_SHORT_HDR;
    end else if (destination_seen_nxt != local_address &&
                 destination_seen_nxt != BROADCAST_ADDR) begin
      verdict = VERDICT_WRONG_DEST;
    end else if (fold2 != CSUM_GOOD) begin
      verdict = VERDICT_BAD_CSUM;
    end else begin
      verdict = VERDICT_ACCEPT;
    end
    result.verdict       = verdict;
    result.packet_length = byte_count_nxt;
  end

  // per-packet state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && item.last_byte)) begin
      byte_count_r        <= '0;
      header_words_r      <= '0;
      version_seen_r      <= '0;
      ttl_seen_r          <= '0;
      destination_seen_r  <= '0;
      pending_high_byte_r <= '0;
      ones_sum_r          <= '0;
    end else if (fire) begin
      byte_count_r        <= byte_count_nxt;
      header_words_r      <= header_words_nxt;
      version_seen_r      <= version_seen_nxt;
      ttl_seen_r          <= ttl_seen_nxt;
      destination_seen_r  <= destination_seen_nxt;
      pending_high_byte_r <= pending_high_byte_nxt;
      ones_sum_r          <= ones_sum_nxt;
    end
  end

endmodule

>>> sv/ipv4_receive_header_check.sv
// Checks a received IPv4 packet presented one byte per transaction, header
// first, with last_byte marking the final byte. Bytes are taken at one per
// cycle unless stalled: a byte is registered on entry, then updates the field
// captures and header ones'-complement sum as it leaves that register. Only
// a packet's last byte yields a result (verdict and saturated packet length)
// in the output register as that byte leaves; the input stalls only while a
// finished result is still waiting there and a new last byte needs the slot.
// Verdicts are checked in order truncated, ttl zero, bad version, short header,
// wrong destination (neither cfg address nor 255.255.255.255), bad checksum.
// The user must write cfg_local_address only while idle; it is not enforced.
module ipv4_receive_header_check (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_local_address,
  input  logic                in_valid,
  output logic                in_stall,
  input  iphc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output iphc_pkg::out_item_t out_data
);
  import iphc_pkg::*;

  logic [31:0] local_address_r;
  logic        s1_valid_r;
  in_item_t    s1_item_r;
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic        slot_free;
  logic        s1_fire;
  out_item_t   result;

  // local address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_address_r <= '0;
    end else if (cfg_we) begin
      local_address_r <= cfg_local_address;
    end
  end

  // handshake: only a last byte needs the output slot
  assign slot_free = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && (!s1_item_r.last_byte || slot_free);
  assign in_stall  = s1_valid_r && !s1_fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  iphc_accum u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (s1_fire),
    .item          (s1_item_r),
    .local_address (local_address_r),
    .result        (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_item_r.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_item_r.last_byte) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
